// File: rtl/pss_pkg.sv
// Shared types, widths and constants for the point stream smoother.
// Used by the top level and its port checker; depends on nothing else.

package pss_pkg;

   localparam int COORD_W    = 24;
   localparam int ALPHA_W    = 16;
   localparam int MODE_W     = 2;
   localparam int HIST_DEPTH = 4;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
   localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ALPHA_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 1'd1;

   localparam logic [MODE_W-1:0] MODE_CUBIC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FCAST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG   = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h8000;

   localparam int OPND_W  = COORD_W + 1;
   localparam int COEF_W  = ALPHA_W + 1;
   localparam int PROD_W  = OPND_W + COEF_W;
   localparam int NUM_W   = COORD_W + ALPHA_W;
   localparam int QUO_W   = COORD_W + 1;
   localparam int DIVR_W  = ALPHA_W + 1;
   localparam int DCNT_W  = $clog2(QUO_W);
   localparam int SUM_W   = COORD_W + 2;
   localparam int TOT_W   = SUM_W + 1;

   localparam int CUBIC_NEW = 69;
   localparam int CUBIC_DIV = 70;

   // halved cubic sum magnitude stays below 2^RCP_IN_W; divide it by half the divisor
   localparam int CUBIC_HALF = CUBIC_DIV / 2;
   localparam int RCP_IN_W   = COORD_W + 5;
   localparam int RCP_SHIFT  = RCP_IN_W + $clog2(CUBIC_HALF);
   localparam int RCP_M_W    = RCP_IN_W + 1;
   localparam logic [RCP_M_W-1:0] RCP_MAGIC =
      RCP_M_W'(((longint'(1) << RCP_SHIFT) + CUBIC_HALF - 1) / CUBIC_HALF);

   localparam int MUL_A_W = RCP_IN_W + 1;
   localparam int MUL_B_W = RCP_M_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [DIVR_W-1:0] ALPHA_ONE = DIVR_W'(1) << ALPHA_W;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x_in;
      logic signed [COORD_W-1:0] y_in;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_out;
      logic signed [COORD_W-1:0] y_out;
      logic                      passed_through;
   } rsp_word_type;

   // weights of the stored taps, newest first
   function automatic logic signed [COEF_W-1:0] cubic_coef(input logic [HIST_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         2'd0: c = COEF_W'(4);
         2'd1: c = COEF_W'(-6);
         2'd2: c = COEF_W'(4);
         2'd3: c = COEF_W'(-1);
      endcase
      return c;
   endfunction

endpackage

// File: rtl/point_stream_smoother.sv
// Point stream smoother top level: history, shared multiplier, restoring divider, sequencer.
// Depends on pss_pkg.
//
// Channel  Dir  Handshake              Word
// req      in   req_valid / req_stall  req_word_type: x_in, y_in
// rsp      out  rsp_valid / rsp_stall  rsp_word_type: x_out, y_out, passed_through
// csr      in   csr_wr_en              csr_index, csr_wr_data
//
// Pass-through, average and unused mode: the result is formed as the word is taken, then sent from the done state.
// Forecast mode: eight exponential steps, each through the subtract, multiply and add states on
// the shared multiplier, then a restoring divide of COORD_W + 1 quotient bits.
// Cubic mode: a five-term multiply-accumulate and a reciprocal multiply per axis.
// One word at a time; a finished word waits in the output register while the next is taken.
// Reset is synchronous; history count clears, history entries stay unknown until written.

module point_stream_smoother
   import pss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] ST_MAC_MUL  = 4'd1;
   localparam logic [ST_W-1:0] ST_MAC_ADD  = 4'd2;
   localparam logic [ST_W-1:0] ST_EMA_SUB  = 4'd3;
   localparam logic [ST_W-1:0] ST_EMA_MUL  = 4'd4;
   localparam logic [ST_W-1:0] ST_EMA_ADD  = 4'd5;
   localparam logic [ST_W-1:0] ST_FC_SUB   = 4'd6;
   localparam logic [ST_W-1:0] ST_FC_MUL   = 4'd7;
   localparam logic [ST_W-1:0] ST_DIV_LOAD = 4'd8;
   localparam logic [ST_W-1:0] ST_DIV_STEP = 4'd9;
   localparam logic [ST_W-1:0] ST_DIV_END  = 4'd10;
   localparam logic [ST_W-1:0] ST_DONE     = 4'd11;
   localparam logic [ST_W-1:0] ST_RCP_MUL  = 4'd12;

   logic [ST_W-1:0]           state_ff, state_in;
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic [ALPHA_W-1:0]        alpha_ff, alpha_in;
   logic [HIST_CNT_W-1:0]     hcnt_ff, hcnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [COORD_W-1:0] hx_ff [HIST_DEPTH];
   logic signed [COORD_W-1:0] hx_in [HIST_DEPTH];
   logic signed [COORD_W-1:0] hy_ff [HIST_DEPTH];
   logic signed [COORD_W-1:0] hy_in [HIST_DEPTH];
   logic signed [COORD_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [HIST_CNT_W-1:0]     step_ff, step_in;
   logic                      s2_sel_ff, s2_sel_in;
   logic                      coord_y_ff, coord_y_in;
   logic signed [OPND_W-1:0]  opnd_ff, opnd_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic signed [COORD_W-1:0] s1_ff, s1_in, s2_ff, s2_in;
   logic signed [SUM_W-1:0]   addend_ff, addend_in;
   logic [DIVR_W-1:0]         divr_ff, divr_in;
   logic [DIVR_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [RCP_IN_W-1:0]       rmag_ff, rmag_in;
   logic                      neg_ff, neg_in;
   logic                      ovf_ff, ovf_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic signed [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                      res_pass_ff, res_pass_in;
   rsp_word_type              rsp_data_ff, rsp_data_in;

   logic [HIST_IDX_W-1:0]     rd_idx;
   logic signed [COORD_W-1:0] tap_x, tap_y, tap_c, new_c;
   logic                      term_new;
   logic                      hist_full;
   logic signed [OPND_W-1:0]  mac_opnd;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      sub_first;
   logic signed [COORD_W-1:0] sub_a, sub_b;
   logic signed [OPND_W-1:0]  sub_d;
   logic signed [COORD_W-1:0] ema_base, ema_next;
   logic signed [PROD_W-1:0]  num_sel;
   logic                      num_neg;
   logic [PROD_W-1:0]         num_mag;
   logic [NUM_W-1:0]          num_low;
   logic [NUM_W-QUO_W-1:0]    num_top;
   logic [DIVR_W-1:0]         divr_sel;
   logic [DIVR_W:0]           trial, trial_diff;
   logic                      trial_ge;
   logic signed [SUM_W-1:0]   q_signed;
   logic signed [TOT_W-1:0]   tot;
   logic signed [COORD_W-1:0] sat_val;
   logic signed [OPND_W-1:0]  avg_x_sum, avg_y_sum;

   assign rd_idx    = step_ff[HIST_IDX_W-1:0];
   assign tap_x     = hx_ff[rd_idx];
   assign tap_y     = hy_ff[rd_idx];
   assign tap_c     = coord_y_ff ? tap_y : tap_x;
   assign new_c     = coord_y_ff ? ny_ff : nx_ff;
   assign term_new  = (step_ff == HIST_CNT_W'(HIST_DEPTH));
   assign hist_full = (hcnt_ff == HIST_CNT_W'(HIST_DEPTH));

   // shared multiplier
   assign mac_opnd = term_new ? OPND_W'(new_c) : OPND_W'(tap_c);
   assign mul_a    = (state_ff == ST_MAC_MUL) ? MUL_A_W'(mac_opnd)
                   : (state_ff == ST_RCP_MUL) ? $signed({1'b0, rmag_ff})
                                              : MUL_A_W'(opnd_ff);
   assign mul_b    = (state_ff == ST_MAC_MUL)
                     ? MUL_B_W'(term_new ? COEF_W'(CUBIC_NEW) : cubic_coef(rd_idx))
                   : (state_ff == ST_RCP_MUL) ? $signed({1'b0, RCP_MAGIC})
                                              : MUL_B_W'($signed({1'b0, alpha_ff}));
   assign mul_p    = mul_a * mul_b;

   // shared subtractor
   assign sub_first = (state_ff == ST_EMA_SUB) && !s2_sel_ff;
   assign sub_a     = sub_first ? tap_y : s1_ff;
   assign sub_b     = sub_first ? s1_ff : s2_ff;
   assign sub_d     = OPND_W'(sub_a) - OPND_W'(sub_b);

   assign ema_base  = s2_sel_ff ? s2_ff : s1_ff;
   assign ema_next  = COORD_W'(SUM_W'(ema_base) + SUM_W'(prod_ff >>> ALPHA_W));

   // divider operand preparation
   assign num_sel   = (mode_ff == MODE_CUBIC) ? acc_ff : prod_ff;
   assign num_neg   = num_sel[PROD_W-1];
   assign num_mag   = num_neg ? -num_sel : num_sel;
   assign num_low   = num_mag[NUM_W-1:0];
   assign num_top   = num_low[NUM_W-1:QUO_W];
   assign divr_sel  = ALPHA_ONE - DIVR_W'(alpha_ff);

   // one restoring step
   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge   = trial >= {1'b0, divr_ff};
   assign trial_diff = trial - {1'b0, divr_ff};

   assign q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign tot      = TOT_W'(addend_ff) + TOT_W'(q_signed);

   always_comb begin
      if (ovf_ff) begin
         sat_val = neg_ff ? COORD_MIN : COORD_MAX;
      end else if (tot > TOT_W'(COORD_MAX)) begin
         sat_val = COORD_MAX;
      end else if (tot < TOT_W'(COORD_MIN)) begin
         sat_val = COORD_MIN;
      end else begin
         sat_val = tot[COORD_W-1:0];
      end
   end

   assign avg_x_sum = OPND_W'(hx_ff[0]) + OPND_W'(req_data.x_in);
   assign avg_y_sum = OPND_W'(hy_ff[0]) + OPND_W'(req_data.y_in);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      alpha_in     = alpha_ff;
      hcnt_in      = hcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      step_in      = step_ff;
      s2_sel_in    = s2_sel_ff;
      coord_y_in   = coord_y_ff;
      opnd_in      = opnd_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      addend_in    = addend_ff;
      divr_in      = divr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rmag_in      = rmag_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      dcnt_in      = dcnt_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_pass_in  = res_pass_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:  mode_in  = csr_wr_data[MODE_W-1:0];
            CSR_ALPHA: alpha_in = csr_wr_data[ALPHA_W-1:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               nx_in       = req_data.x_in;
               ny_in       = req_data.y_in;
               res_x_in    = req_data.x_in;
               res_y_in    = req_data.y_in;
               res_pass_in = 1'b0;
               step_in     = '0;
               s2_sel_in   = 1'b0;
               coord_y_in  = 1'b0;
               acc_in      = '0;
               addend_in   = '0;
               s1_in       = hy_ff[HIST_DEPTH-1];
               s2_in       = hy_ff[HIST_DEPTH-1];
               state_in    = ST_DONE;
               unique case (mode_ff)
                  MODE_CUBIC: begin
                     if (hist_full) begin
                        state_in = ST_MAC_MUL;
                     end else begin
                        res_pass_in = 1'b1;
                     end
                  end
                  MODE_FCAST: begin
                     if (hist_full) begin
                        step_in  = HIST_CNT_W'(HIST_DEPTH - 1);
                        state_in = ST_EMA_SUB;
                     end else begin
                        res_pass_in = 1'b1;
                     end
                  end
                  MODE_AVG: begin
                     if (hcnt_ff != '0) begin
                        res_x_in = avg_x_sum[COORD_W:1];
                        res_y_in = avg_y_sum[COORD_W:1];
                     end else begin
                        res_pass_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MAC_MUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_MAC_ADD;
         end
         ST_MAC_ADD: begin
            acc_in = acc_ff + prod_ff;
            if (term_new) begin
               state_in = ST_DIV_LOAD;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MAC_MUL;
            end
         end
         ST_EMA_SUB: begin
            opnd_in  = sub_d;
            state_in = ST_EMA_MUL;
         end
         ST_EMA_MUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_EMA_ADD;
         end
         ST_EMA_ADD: begin
            if (!s2_sel_ff) begin
               s1_in     = ema_next;
               s2_sel_in = 1'b1;
               state_in  = ST_EMA_SUB;
            end else begin
               s2_in     = ema_next;
               s2_sel_in = 1'b0;
               if (step_ff == '0) begin
                  state_in = ST_FC_SUB;
               end else begin
                  step_in  = step_ff - 1'b1;
                  state_in = ST_EMA_SUB;
               end
            end
         end
         ST_FC_SUB: begin
            opnd_in   = sub_d;
            addend_in = SUM_W'(s1_ff) + SUM_W'(s1_ff) - SUM_W'(s2_ff);
            state_in  = ST_FC_MUL;
         end
         ST_FC_MUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            neg_in = num_neg;
            if (mode_ff == MODE_CUBIC) begin
               rmag_in  = num_mag[RCP_IN_W:1];
               ovf_in   = 1'b0;
               state_in = ST_RCP_MUL;
            end else begin
               divr_in  = divr_sel;
               rem_in   = DIVR_W'(num_top);
               quo_in   = num_low[QUO_W-1:0];
               ovf_in   = DIVR_W'(num_top) >= divr_sel;
               dcnt_in  = DCNT_W'(QUO_W - 1);
               state_in = ST_DIV_STEP;
            end
         end
         ST_RCP_MUL: begin
            quo_in   = mul_p[RCP_SHIFT +: QUO_W];
            state_in = ST_DIV_END;
         end
         ST_DIV_STEP: begin
            rem_in = trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            if (dcnt_ff == '0) begin
               state_in = ST_DIV_END;
            end else begin
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         ST_DIV_END: begin
            if (mode_ff == MODE_CUBIC && !coord_y_ff) begin
               res_x_in   = sat_val;
               coord_y_in = 1'b1;
               step_in    = '0;
               acc_in     = '0;
               state_in   = ST_MAC_MUL;
            end else begin
               res_y_in = sat_val;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{x_out: res_x_ff, y_out: res_y_ff,
                                passed_through: res_pass_ff};
               for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                  hx_in[i] = hx_ff[i-1];
                  hy_in[i] = hy_ff[i-1];
               end
               hx_in[0] = nx_ff;
               hy_in[0] = ny_ff;
               if (!hist_full) begin
                  hcnt_in = hcnt_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_CUBIC;
         alpha_ff     <= ALPHA_RESET;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         alpha_ff     <= alpha_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      step_ff     <= step_in;
      s2_sel_ff   <= s2_sel_in;
      coord_y_ff  <= coord_y_in;
      opnd_ff     <= opnd_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      addend_ff   <= addend_in;
      divr_ff     <= divr_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rmag_ff     <= rmag_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      dcnt_ff     <= dcnt_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_pass_ff <= res_pass_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/pss_checker.sv
// Port-level assertions for the point stream smoother, bound to the top level.
// Depends on pss_pkg and point_stream_smoother.

module pss_checker
   import pss_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word dropped or changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken again in the cycle after an accept");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp word appeared while no req word was in work");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("reset left a word pending or the block busy");

endmodule

bind point_stream_smoother pss_checker u_pss_checker (.*);
